@@ rtl/core/ahcc_pkg.sv @@
`timescale 1ns / 1ps

package ahcc_pkg;

   localparam int DEF_SAMPLE_BITS = 16;
   localparam int DEF_COUNT_BITS  = 16;

   localparam int CSR_ADDR_BITS  = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int COUNT_OUT_BITS = 16;

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MIN_AMPLITUDE  = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LOWER_FRACTION = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_UPPER_FRACTION = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CYCLE_LIMIT    = 2'd3;

   localparam logic [CSR_DATA_BITS-1:0] RST_MIN_AMPLITUDE  = 16'd328;
   localparam logic [CSR_DATA_BITS-1:0] RST_LOWER_FRACTION = 16'd16384;
   localparam logic [CSR_DATA_BITS-1:0] RST_UPPER_FRACTION = 16'd49152;
   localparam logic [CSR_DATA_BITS-1:0] RST_CYCLE_LIMIT    = 16'd10;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] min_amplitude;
      logic [CSR_DATA_BITS-1:0] lower_fraction;
      logic [CSR_DATA_BITS-1:0] upper_fraction;
      logic [CSR_DATA_BITS-1:0] cycle_limit;
   } cfg_type;

endpackage

@@ rtl/core/ahcc_update.sv @@
`timescale 1ns / 1ps

module ahcc_update #(
   parameter int SAMPLE_BITS = ahcc_pkg::DEF_SAMPLE_BITS,
   parameter int COUNT_BITS  = ahcc_pkg::DEF_COUNT_BITS
) (
   input  ahcc_pkg::cfg_type         cfg,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [SAMPLE_BITS-1:0] run_min,
   input  logic signed [SAMPLE_BITS-1:0] run_max,
   input  logic                      arm,
   input  logic [COUNT_BITS-1:0]     count,
   output logic signed [SAMPLE_BITS-1:0] next_min,
   output logic signed [SAMPLE_BITS-1:0] next_max,
   output logic                      next_arm,
   output logic [COUNT_BITS-1:0]     next_count,
   output logic                      amp_ok
);
   import ahcc_pkg::*;

   localparam int CMP_W  = (SAMPLE_BITS > CSR_DATA_BITS) ? SAMPLE_BITS : CSR_DATA_BITS;
   localparam int PROD_W = SAMPLE_BITS + CSR_DATA_BITS;
   localparam int TH_W   = SAMPLE_BITS + 2;
   localparam int CW     = ((COUNT_BITS > CSR_DATA_BITS) ? COUNT_BITS : CSR_DATA_BITS) + 1;
   localparam logic [CW-1:0] COUNT_MAX = {{(CW-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

   logic [SAMPLE_BITS:0]   diff;
   logic [SAMPLE_BITS-1:0] span;
   logic [PROD_W-1:0]      plo;
   logic [PROD_W-1:0]      phi;
   logic [PROD_W:0]        phi_up;
   logic signed [TH_W-1:0] low_th;
   logic signed [TH_W-1:0] high_th;
   logic signed [TH_W-1:0] s_ext;
   logic [CW-1:0]          tgt_ext;
   logic [CW-1:0]          limit;
   logic [CW-1:0]          inc;
   logic [CW-1:0]          sat;

   always_comb begin
      next_min = (sample < run_min) ? sample : run_min;
      next_max = (sample > run_max) ? sample : run_max;

      // span never goes negative once the current sample is folded in
      diff = {next_max[SAMPLE_BITS-1], next_max} - {next_min[SAMPLE_BITS-1], next_min};
      span = diff[SAMPLE_BITS-1:0];
      amp_ok = CMP_W'(span) >= CMP_W'(cfg.min_amplitude);

      plo    = PROD_W'(span) * PROD_W'(cfg.lower_fraction);
      phi    = PROD_W'(span) * PROD_W'(cfg.upper_fraction);
      phi_up = {1'b0, phi} + (PROD_W+1)'(16'hFFFF);

      // floor for the low threshold, ceiling for the high one
      low_th  = $signed({{2{next_min[SAMPLE_BITS-1]}}, next_min})
              + $signed({2'b00, plo[PROD_W-1:CSR_DATA_BITS]});
      high_th = $signed({{2{next_min[SAMPLE_BITS-1]}}, next_min})
              + $signed({1'b0, phi_up[PROD_W:CSR_DATA_BITS]});
      s_ext   = $signed({{2{sample[SAMPLE_BITS-1]}}, sample});

      tgt_ext = CW'(cfg.cycle_limit);
      limit   = (tgt_ext < COUNT_MAX) ? tgt_ext : COUNT_MAX;
      inc     = CW'(count) + CW'(1);
      sat     = (inc < limit) ? inc : limit;

      next_arm   = arm;
      next_count = count;
      if (amp_ok) begin
         if (s_ext <= low_th) begin
            next_arm = 1'b1;
         end else if (arm && (s_ext >= high_th)) begin
            next_arm   = 1'b0;
            next_count = sat[COUNT_BITS-1:0];
         end
      end
   end

endmodule

@@ rtl/core/adaptive_hysteresis_cycle_counter_top.sv @@
`timescale 1ns / 1ps
// The accepted sample is held in the input register; the update result is then written into
// the output register, which holds it until the result handshake.
// Throughput: 1 item per cycle while the result side does not stall; the min/max/arm/count
// update is combinational between the input register and the output register.
// Reset (synchronous, active high): empties both register stages, loads the
// register defaults, sets run min/max to the extreme codes, clears arm and count.
module adaptive_hysteresis_cycle_counter_top #(
   parameter int SAMPLE_BITS = ahcc_pkg::DEF_SAMPLE_BITS,
   parameter int COUNT_BITS  = ahcc_pkg::DEF_COUNT_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  req_tdata,  // sample
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,  // cycle_count, armed, amplitude_ok
   input  logic                              csr_we,
   input  logic [ahcc_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [ahcc_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import ahcc_pkg::*;

   localparam int CNT_EXT = (COUNT_BITS > COUNT_OUT_BITS) ? COUNT_BITS : COUNT_OUT_BITS;

   cfg_type                       cfg_ff;
   logic                          in_valid_ff;
   logic signed [SAMPLE_BITS-1:0] in_sample_ff;
   logic signed [SAMPLE_BITS-1:0] run_min_ff;
   logic signed [SAMPLE_BITS-1:0] run_max_ff;
   logic                          arm_ff;
   logic [COUNT_BITS-1:0]         count_ff;
   logic                          out_valid_ff;
   logic [COUNT_OUT_BITS-1:0]     out_count_ff;
   logic                          out_armed_ff;
   logic                          out_amp_ff;

   logic signed [SAMPLE_BITS-1:0] run_min_in;
   logic signed [SAMPLE_BITS-1:0] run_max_in;
   logic                          arm_in;
   logic [COUNT_BITS-1:0]         count_in;
   logic                          amp_ok;
   logic [CNT_EXT-1:0]            count_wide;
   logic                          advance;
   logic                          fire;

   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign count_wide = CNT_EXT'(count_in);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_amp_ff, out_armed_ff, out_count_ff};

   ahcc_update #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_update (
      .cfg        (cfg_ff),
      .sample     (in_sample_ff),
      .run_min    (run_min_ff),
      .run_max    (run_max_ff),
      .arm        (arm_ff),
      .count      (count_ff),
      .next_min   (run_min_in),
      .next_max   (run_max_in),
      .next_arm   (arm_in),
      .next_count (count_in),
      .amp_ok     (amp_ok)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_amplitude  <= RST_MIN_AMPLITUDE;
         cfg_ff.lower_fraction <= RST_LOWER_FRACTION;
         cfg_ff.upper_fraction <= RST_UPPER_FRACTION;
         cfg_ff.cycle_limit    <= RST_CYCLE_LIMIT;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MIN_AMPLITUDE:  cfg_ff.min_amplitude  <= csr_wdata;
            CSR_LOWER_FRACTION: cfg_ff.lower_fraction <= csr_wdata;
            CSR_UPPER_FRACTION: cfg_ff.upper_fraction <= csr_wdata;
            CSR_CYCLE_LIMIT:    cfg_ff.cycle_limit    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         run_min_ff   <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         run_max_ff   <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         arm_ff       <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
            run_min_ff   <= run_min_in;
            run_max_ff   <= run_max_in;
            arm_ff       <= arm_in;
            count_ff     <= count_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_sample_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
      if (fire) begin
         out_count_ff <= count_wide[COUNT_OUT_BITS-1:0];
         out_armed_ff <= arm_in;
         out_amp_ff   <= amp_ok;
      end
   end

endmodule

@@ sim/ahcc_cycle_checker.sv @@
`timescale 1ns / 1ps

// Watches both streams and the register port, predicts every result item of the
// hysteresis counter and compares it with what the block returns.
module ahcc_cycle_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [15:0]                        req_tdata,   // sample
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [23:0]                        rsp_tdata,   // cycle_count, armed, amplitude_ok
   input  logic                               csr_we,
   input  logic [ahcc_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [ahcc_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int                                 errors,
   output int                                 pending,
   output int                                 checked,
   output int                                 completions
);
   import ahcc_pkg::*;

   localparam int EXP_DEPTH = 16;

   typedef struct packed {
      logic        amp_ok;
      logic        armed;
      logic [15:0] cycle_count;
   } result_type;

   cfg_type            cfg;
   logic signed [15:0] lo_seen;
   logic signed [15:0] hi_seen;
   logic               armed_q;
   logic [15:0]        count_q;
   result_type         exp_buf[EXP_DEPTH];
   int                 exp_wr;
   int                 exp_rd;
   int                 exp_cnt;
   int                 n_err;
   int                 n_chk;
   int                 n_cyc;

   task automatic report(input string what, input longint want, input longint seen);
      n_err++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
   endtask

   task automatic step_detector(input logic signed [15:0] s, output result_type r);
      longint sv, mn, mx, span, lf, uf, ma, low_th, high_th;
      logic [16:0] bumped;
      r = '0;
      if (s < lo_seen) lo_seen = s;
      if (s > hi_seen) hi_seen = s;
      sv = s;
      mn = lo_seen;
      mx = hi_seen;
      lf = cfg.lower_fraction;
      uf = cfg.upper_fraction;
      ma = cfg.min_amplitude;
      if (mx >= mn) begin
         span = mx - mn;
         if (span >= ma) begin
            // floor for the low side, ceiling for the high side
            low_th  = mn + ((span * lf) >> 16);
            high_th = mn + ((span * uf + 65535) >> 16);
            r.amp_ok = 1'b1;
            if (sv <= low_th) begin
               armed_q = 1'b1;
            end else if (armed_q && sv >= high_th) begin
               armed_q = 1'b0;
               bumped  = count_q + 17'd1;
               // a lowered limit pulls the count down only when the next swing completes
               count_q = (bumped < {1'b0, cfg.cycle_limit}) ? bumped[15:0] : cfg.cycle_limit;
               n_cyc++;
            end
         end
      end
      r.armed       = armed_q;
      r.cycle_count = count_q;
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         cfg.min_amplitude  = RST_MIN_AMPLITUDE;
         cfg.lower_fraction = RST_LOWER_FRACTION;
         cfg.upper_fraction = RST_UPPER_FRACTION;
         cfg.cycle_limit    = RST_CYCLE_LIMIT;
         lo_seen = {1'b0, {15{1'b1}}};
         hi_seen = {1'b1, 15'd0};
         armed_q = 1'b0;
         count_q = '0;
         exp_wr  = 0;
         exp_rd  = 0;
         exp_cnt = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (exp_cnt == 0) begin
               n_err++;
               $display("%0t: result item with none expected, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               want    = exp_buf[exp_rd];
               exp_rd  = (exp_rd + 1) % EXP_DEPTH;
               exp_cnt = exp_cnt - 1;
               n_chk++;
               if (rsp_tdata[15:0] !== want.cycle_count)
                  report("cycle_count", want.cycle_count, rsp_tdata[15:0]);
               if (rsp_tdata[16] !== want.armed)
                  report("armed", want.armed, rsp_tdata[16]);
               if (rsp_tdata[17] !== want.amp_ok)
                  report("amplitude_ok", want.amp_ok, rsp_tdata[17]);
               if (rsp_tdata[23:18] !== 6'd0)
                  report("padding", 0, rsp_tdata[23:18]);
            end
         end
         if (req_tvalid && req_tready) begin
            step_detector(req_tdata, want);
            if (exp_cnt == EXP_DEPTH) begin
               n_err++;
               $display("%0t: items in flight, expected at most %0d, actual %0d",
                        $time, EXP_DEPTH, exp_cnt + 1);
            end else begin
               exp_buf[exp_wr] = want;
               exp_wr  = (exp_wr + 1) % EXP_DEPTH;
               exp_cnt = exp_cnt + 1;
            end
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_MIN_AMPLITUDE:  cfg.min_amplitude  = csr_wdata;
               CSR_LOWER_FRACTION: cfg.lower_fraction = csr_wdata;
               CSR_UPPER_FRACTION: cfg.upper_fraction = csr_wdata;
               CSR_CYCLE_LIMIT:    cfg.cycle_limit    = csr_wdata;
               default: ;
            endcase
         end
      end
      errors      <= n_err;
      pending     <= exp_cnt;
      checked     <= n_chk;
      completions <= n_cyc;
   end

endmodule

@@ sim/adaptive_hysteresis_cycle_counter_top_tb.sv @@
`timescale 1ns / 1ps

module adaptive_hysteresis_cycle_counter_top_tb;
   import ahcc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int CENTER      = 100;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [15:0]              req_tdata  = '0;   // sample
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [23:0]              rsp_tdata;         // cycle_count, armed, amplitude_ok
   logic                     csr_we     = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata  = '0;

   int      errors, pending, checked, completions;
   int      items_sent = 0;
   int      settings_used = 1;
   bit      tx_quiet = 1'b0;
   bit      rx_quiet = 1'b0;
   int      rx_hold = 0;
   int      rx_mode_left = 0;
   cfg_type cfg_now;

   adaptive_hysteresis_cycle_counter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   ahcc_cycle_checker detector_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .errors      (errors),
      .pending     (pending),
      .checked     (checked),
      .completions (completions)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mostly short gaps, a few long ones, none at all while quiet
   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_quiet     = ($urandom_range(0, 3) == 0);
            rx_mode_left = $urandom_range(20, 200);
         end
         rx_mode_left--;
         if (rx_hold > 0) begin
            rsp_tready <= 1'b0;
            rx_hold--;
         end else begin
            rsp_tready <= 1'b1;
            rx_hold = pick_gap(rx_quiet);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: timeout, %0d result items still expected", $time, pending);
      $display("adaptive_hysteresis_cycle_counter_top_tb: FAIL");
      $finish;
   end

   task automatic send_item(input int s);
      int g;
      g = pick_gap(tx_quiet);
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s[15:0];
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic set_config(input cfg_type c);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_MIN_AMPLITUDE;
      csr_wdata <= c.min_amplitude;
      @(posedge clock);
      csr_addr  <= CSR_LOWER_FRACTION;
      csr_wdata <= c.lower_fraction;
      @(posedge clock);
      csr_addr  <= CSR_UPPER_FRACTION;
      csr_wdata <= c.upper_fraction;
      @(posedge clock);
      csr_addr  <= CSR_CYCLE_LIMIT;
      csr_wdata <= c.cycle_limit;
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_now = c;
      settings_used++;
   endtask

   function automatic cfg_type rand_cfg(int w);
      cfg_type c;
      int r;
      int amp_top;
      amp_top = (4 * w > 65535) ? 65535 : 4 * w;
      r = $urandom_range(0, 9);
      if (r == 0)      c.min_amplitude = 16'd0;
      else if (r == 1) c.min_amplitude = 16'hFFFF;
      else             c.min_amplitude = 16'($urandom_range(0, amp_top));
      r = $urandom_range(0, 9);
      if (r == 0) begin
         c.lower_fraction = 16'd0;
         c.upper_fraction = 16'hFFFF;
      end else if (r == 1) begin
         c.lower_fraction = 16'hFFFF;
         c.upper_fraction = 16'd0;
      end else if (r < 8) begin
         c.lower_fraction = 16'($urandom_range(0, 32767));
         c.upper_fraction = 16'($urandom_range(32768, 65535));
      end else begin
         c.lower_fraction = 16'($urandom_range(0, 65535));
         c.upper_fraction = 16'($urandom_range(0, 65535));
      end
      r = $urandom_range(0, 9);
      if (r == 0)      c.cycle_limit = 16'd0;
      else if (r == 1) c.cycle_limit = 16'hFFFF;
      else if (r < 6)  c.cycle_limit = 16'($urandom_range(1, 20));
      else             c.cycle_limit = 16'($urandom_range(0, 65535));
      return c;
   endfunction

   // Swings between the bottom and top eighths of a window so the detector
   // keeps arming and counting; the rest is noise inside the window, or over
   // the whole code range when wild is set.
   task automatic random_phase(input int w, input int n, input bit wild);
      longint lo, hi, v;
      int quarter, run_left, r, offs;
      bit up;
      lo = CENTER - w;
      if (lo < -32768) lo = -32768;
      hi = CENTER + w;
      if (hi > 32767) hi = 32767;
      quarter  = int'((hi - lo) / 8) + 1;
      run_left = 0;
      up       = 1'b0;
      repeat (n) begin
         if ($urandom_range(0, 39) == 0) tx_quiet = ($urandom_range(0, 2) == 0);
         r = $urandom_range(0, 99);
         if (r < 85) begin
            if (run_left == 0) begin
               up       = ~up;
               run_left = $urandom_range(1, 5);
            end
            run_left--;
            offs = $urandom_range(0, quarter);
            v = up ? hi - offs : lo + offs;
         end else if (r < 95 || !wild) begin
            offs = $urandom_range(0, int'(hi - lo));
            v = lo + offs;
         end else begin
            offs = $urandom_range(0, 65535);
            v = offs - 32768;
         end
         send_item(int'(v));
      end
   endtask

   initial begin
      cfg_type c;
      int widths[8] = '{250, 400, 700, 1500, 3000, 8000, 16000, 33000};
      cfg_now.min_amplitude  = RST_MIN_AMPLITUDE;
      cfg_now.lower_fraction = RST_LOWER_FRACTION;
      cfg_now.upper_fraction = RST_UPPER_FRACTION;
      cfg_now.cycle_limit    = RST_CYCLE_LIMIT;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: span too small at first, then arm/count
      tx_quiet = 1'b1;
      send_item(0);
      send_item(100);
      send_item(-1);
      send_item(300);
      send_item(-100);
      send_item(300);
      send_item(-100);
      send_item(250);
      send_item(50);
      send_item(-50);
      send_item(200);

      // low threshold above high: low test wins
      tx_quiet = 1'b0;
      c = cfg_now;
      c.min_amplitude  = 16'd0;
      c.lower_fraction = 16'hFFFF;
      c.upper_fraction = 16'd0;
      wait_idle();
      set_config(c);
      send_item(100);
      send_item(300);
      send_item(300);

      // target lowered below the count
      c.lower_fraction = RST_LOWER_FRACTION;
      c.upper_fraction = RST_UPPER_FRACTION;
      c.cycle_limit    = 16'd2;
      wait_idle();
      set_config(c);
      send_item(-100);
      send_item(300);

      // zero target
      c.cycle_limit = 16'd0;
      wait_idle();
      set_config(c);
      send_item(-100);
      send_item(300);

      // largest amplitude floor, thresholds at the span edges
      c.min_amplitude  = 16'hFFFF;
      c.lower_fraction = 16'd0;
      c.upper_fraction = 16'hFFFF;
      c.cycle_limit    = 16'hFFFF;
      wait_idle();
      set_config(c);
      send_item(-100);
      send_item(300);
      c.min_amplitude = 16'd0;
      wait_idle();
      set_config(c);
      send_item(-100);
      send_item(300);

      // windows only grow, so the span widens phase by phase
      for (int i = 0; i < 8; i++) begin
         wait_idle();
         set_config(rand_cfg(widths[i]));
         random_phase(widths[i], 100, 1'b0);
      end

      // full scale codes under reset settings
      c.min_amplitude  = RST_MIN_AMPLITUDE;
      c.lower_fraction = RST_LOWER_FRACTION;
      c.upper_fraction = RST_UPPER_FRACTION;
      c.cycle_limit    = RST_CYCLE_LIMIT;
      wait_idle();
      set_config(c);
      send_item(-32768);
      send_item(32767);
      send_item(-32768);
      send_item(32767);
      send_item(0);
      send_item(-1);

      repeat (2) begin
         wait_idle();
         set_config(rand_cfg(33000));
         random_phase(33000, 150, 1'b1);
      end

      wait_idle();
      repeat (4) @(posedge clock);
      $display("run covered %0d samples over %0d register settings, %0d result items checked",
               items_sent, settings_used, checked);
      $display("%0d completed low-to-high cycles predicted, %0d mismatches", completions, errors);
      if (errors == 0 && pending == 0)
         $display("adaptive_hysteresis_cycle_counter_top_tb: PASS");
      else
         $display("adaptive_hysteresis_cycle_counter_top_tb: FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/ahcc_pkg.sv
rtl/core/ahcc_update.sv
rtl/core/adaptive_hysteresis_cycle_counter_top.sv
sim/ahcc_cycle_checker.sv
sim/adaptive_hysteresis_cycle_counter_top_tb.sv
